FILE: hdl/tacrr_pkg.sv
package tacrr_pkg;

  // geometry
  localparam int unsigned ENTRIES   = 16;
  localparam int unsigned KEY_BITS  = 64;
  localparam int unsigned DATA_BITS = 64;
  localparam int unsigned IDX_W     = $clog2(ENTRIES);
  localparam int unsigned CNT_W     = $clog2(ENTRIES + 1);
  localparam int unsigned SLOT_W    = 4;

  // victim lfsr
  localparam int unsigned    LFSR_W     = 16;
  localparam logic [15:0]    SEED_RESET = 16'd44257;
  localparam logic [15:0]    LFSR_TAPS  = 16'hB400;
  // floor(2^32 / ENTRIES), used for the modulo by reciprocal
  localparam logic [31:0]    RECIP      = 32'((64'd1 << 32) / ENTRIES);

  // action codes
  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_UPDATE = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // latch the incoming item, restart the scan
    logic rd;     // read the slot under the scan counter
    logic step;   // advance lfsr, start the victim modulo
    logic rem;    // finish the victim modulo
    logic wb;     // write back and load the result register
  } tacrr_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last_rd;      // scan counter sits on the last slot
    logic need_victim;  // add found no free slot
    logic out_free;     // result register can take a new item
  } tacrr_sts_t;

  // one galois step, right shift
  function automatic logic [15:0] lfsr_next(input logic [15:0] v);
    logic [15:0] s;
    s = v >> 1;
    if (v[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

endpackage

FILE: hdl/tagged_assoc_cache_random_replace.sv
// channel   | dir | handshake             | contents
// s_axis    | in  | tvalid/tready         | tdata: action, key, payload; tuser: kind
// m_axis    | out | tvalid/tready         | tdata: slot, read_data; tuser: status
// cfg       | in  | cfg_valid/cfg_ready   | cfg_data: random_seed
//
// After accept the controller loads the item, scans the slots, passes the last-slot state and writes back;
// an add into a full cache first takes an lfsr step and the victim modulo, then returns to idle.
// The slot scan makes one memory read per cycle, with the compare in the cycle after each read.
// Reset clears all valid bits and loads the lfsr with the reset seed.
// A new item is accepted while a result waits on m_axis; write-back stalls
// only when the result register is still full.
module tagged_assoc_cache_random_replace (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input items
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,   // action[1:0], key[65:2], payload[129:66], zero
  input  logic         s_axis_tuser,   // kind
  // result items
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata,   // slot[3:0], read_data[67:4], zero
  output logic         m_axis_tuser,   // status
  // seed register
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [15:0]  cfg_data_i
);

  tacrr_pkg::tacrr_cmd_t cmd;
  tacrr_pkg::tacrr_sts_t sts;
  logic                  status;
  logic [3:0]            slot;
  logic [63:0]           read_data;

  assign cfg_ready_o = 1'b1;

  tacrr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tacrr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .action_i    (s_axis_tdata[1:0]),
    .key_i       (s_axis_tdata[65:2]),
    .kind_i      (s_axis_tuser),
    .payload_i   (s_axis_tdata[129:66]),
    .seed_we_i   (cfg_valid_i && cfg_ready_o),
    .seed_i      (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_o    (status),
    .slot_o      (slot),
    .read_data_o (read_data)
  );

  // pack result item
  assign m_axis_tdata = {4'd0, read_data, slot};
  assign m_axis_tuser = status;

  // an accepted item moves the controller out of idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input still ready after accepting an item");

  // at most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.rd, cmd.step, cmd.rem, cmd.wb}))
    else $error("overlapping datapath commands");

  // a not-found result carries zero slot and zero data
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (slot == 4'd0) && (read_data == 64'd0))
    else $error("not-found result with nonzero slot or data");

  // a result is only loaded by write-back
  a_out_from_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.wb))
    else $error("result appeared without write-back");

endmodule

FILE: hdl/tacrr_ctrl.sv
module tacrr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tacrr_pkg::tacrr_sts_t sts_i,
  output tacrr_pkg::tacrr_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_LAST = 3'd2;
  localparam logic [2:0] ST_STEP = 3'd3;
  localparam logic [2:0] ST_REM  = 3'd4;
  localparam logic [2:0] ST_WB   = 3'd5;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.rd = 1'b1;
        if (sts_i.last_rd) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        state_d = sts_i.need_victim ? ST_STEP : ST_WB;
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = ST_REM;
      end
      ST_REM: begin
        cmd_o.rem = 1'b1;
        state_d   = ST_WB;
      end
      ST_WB: begin
        if (sts_i.out_free) begin
          cmd_o.wb = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/tacrr_dp.sv
module tacrr_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tacrr_pkg::tacrr_cmd_t cmd_i,
  output tacrr_pkg::tacrr_sts_t sts_o,
  // incoming item
  input  logic [1:0]            action_i,
  input  logic [63:0]           key_i,
  input  logic                  kind_i,
  input  logic [63:0]           payload_i,
  // seed write
  input  logic                  seed_we_i,
  input  logic [15:0]           seed_i,
  // result register
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  status_o,
  output logic [3:0]            slot_o,
  output logic [63:0]           read_data_o
);

  localparam int unsigned KB = tacrr_pkg::KEY_BITS;
  localparam int unsigned DB = tacrr_pkg::DATA_BITS;
  localparam int unsigned IW = tacrr_pkg::IDX_W;
  localparam int unsigned CW = tacrr_pkg::CNT_W;

  // slot memories
  logic [KB-1:0] key_mem  [tacrr_pkg::ENTRIES];
  logic          kind_mem [tacrr_pkg::ENTRIES];
  logic [DB-1:0] pay_mem  [tacrr_pkg::ENTRIES];

  logic [tacrr_pkg::ENTRIES-1:0] valid_q;
  logic [15:0]   lfsr_q;
  logic [CW-1:0] cnt_q;
  logic          rd_pend_q;
  logic          found_q;
  logic          out_valid_q;

  // item and scan payload registers
  logic [1:0]    act_q;
  logic [KB-1:0] key_q;
  logic          kind_q;
  logic [DB-1:0] data_q;
  logic [IW-1:0] rd_idx_q;
  logic          rd_vbit_q;
  logic [KB-1:0] key_rd_q;
  logic          kind_rd_q;
  logic [DB-1:0] pay_rd_q;
  logic [IW-1:0] idx_q;
  logic [DB-1:0] rdat_q;
  logic [47:0]   prod_q;
  logic          status_q;
  logic [3:0]    slot_q;
  logic [63:0]   rdata_out_q;

  logic [IW-1:0] addr;
  logic          is_add;
  logic          hit;
  logic          ok;
  logic [15:0]   lfsr_adv;
  logic [15:0]   quo;
  logic [32:0]   rem_full;
  logic [IW:0]   rem;
  logic [IW:0]   rem_adj;
  logic [IW+3:0] idx_ext;

  assign addr   = cnt_q[IW-1:0];
  assign is_add = (act_q == tacrr_pkg::ACT_ADD);

  // compare stage: first free slot for add, first key and kind match for lookup and update
  always_comb begin
    hit = 1'b0;
    if (rd_pend_q && !found_q) begin
      if (is_add) begin
        hit = !rd_vbit_q;
      end else if (act_q == tacrr_pkg::ACT_LOOKUP || act_q == tacrr_pkg::ACT_UPDATE) begin
        hit = rd_vbit_q && (key_rd_q == key_q) && (kind_rd_q == kind_q);
      end
    end
  end

  // victim modulo by reciprocal, one correction
  assign lfsr_adv = tacrr_pkg::lfsr_next(lfsr_q);
  assign quo      = prod_q[47:32];
  assign rem_full = 33'(lfsr_q) - 33'(quo) * 33'(tacrr_pkg::ENTRIES);
  assign rem      = rem_full[IW:0];
  assign rem_adj  = (rem >= (IW+1)'(tacrr_pkg::ENTRIES)) ?
                    rem - (IW+1)'(tacrr_pkg::ENTRIES) : rem;

  // write-back outcome
  assign ok      = is_add || found_q;
  assign idx_ext = (IW+4)'(idx_q);

  assign sts_o.last_rd     = (cnt_q == CW'(tacrr_pkg::ENTRIES - 1));
  assign sts_o.need_victim = is_add && !(found_q || hit);
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      lfsr_q      <= tacrr_pkg::SEED_RESET;
      cnt_q       <= '0;
      rd_pend_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.rd;
      if (cmd_i.load) begin
        cnt_q   <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.rd) begin
          cnt_q <= cnt_q + CW'(1);
        end
        if (hit) begin
          found_q <= 1'b1;
        end
      end
      if (seed_we_i) begin
        lfsr_q <= (seed_i == 16'd0) ? 16'd1 : seed_i;
      end else if (cmd_i.step) begin
        lfsr_q <= lfsr_adv;
      end
      if (cmd_i.wb && is_add) begin
        valid_q[idx_q] <= 1'b1;
      end
      if (cmd_i.wb) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // memories: one read port for the scan, one write port for write-back
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      key_rd_q  <= key_mem[addr];
      kind_rd_q <= kind_mem[addr];
      pay_rd_q  <= pay_mem[addr];
    end
    if (cmd_i.wb && is_add) begin
      key_mem[idx_q]  <= key_q;
      kind_mem[idx_q] <= kind_q;
    end
    if (cmd_i.wb && ok && (is_add || act_q == tacrr_pkg::ACT_UPDATE)) begin
      pay_mem[idx_q] <= data_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= action_i;
      key_q  <= key_i[KB-1:0];
      kind_q <= kind_i;
      data_q <= payload_i[DB-1:0];
    end
    if (cmd_i.rd) begin
      rd_idx_q  <= addr;
      rd_vbit_q <= valid_q[addr];
    end
    if (hit) begin
      idx_q  <= rd_idx_q;
      rdat_q <= pay_rd_q;
    end else if (cmd_i.rem) begin
      idx_q <= rem_adj[IW-1:0];
    end
    if (cmd_i.step) begin
      prod_q <= lfsr_adv * tacrr_pkg::RECIP;
    end
    if (cmd_i.wb) begin
      status_q    <= !ok;
      slot_q      <= ok ? idx_ext[3:0] : 4'd0;
      rdata_out_q <= (ok && act_q == tacrr_pkg::ACT_LOOKUP) ? 64'(rdat_q) : 64'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;
  assign read_data_o = rdata_out_q;

endmodule

FILE: sim/tb.sv
module tb;

  // action code that the block answers with a miss and no state change
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT = 600000;
  localparam int POOL_KEYS   = 12;
  localparam int PHASE_ITEMS = 375;

  typedef struct packed {
    logic             status;
    logic [3:0]       slot;
    logic [63:0]      rdata;
  } cache_reply_t;

  // shadow copy of the cache and the queue of replies it predicts
  class cache_scoreboard;
    logic        slot_valid [tacrr_pkg::ENTRIES];
    logic [63:0] slot_key [tacrr_pkg::ENTRIES];
    logic        slot_kind [tacrr_pkg::ENTRIES];
    logic [63:0] slot_data [tacrr_pkg::ENTRIES];
    logic [15:0] victim_lfsr;
    cache_reply_t expected_replies [$];
    int fail_count;
    int reply_count;

    function new();
      for (int i = 0; i < tacrr_pkg::ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
      end
      victim_lfsr = tacrr_pkg::SEED_RESET;
      fail_count  = 0;
      reply_count = 0;
    endfunction

    // a zero seed would lock the lfsr, so it loads as one
    function void load_seed(logic [15:0] seed);
      victim_lfsr = (seed == 16'd0) ? 16'd1 : seed;
    endfunction

    function void step_lfsr();
      logic fb;
      fb = victim_lfsr[0];
      victim_lfsr = victim_lfsr >> 1;
      if (fb) begin
        victim_lfsr = victim_lfsr ^ tacrr_pkg::LFSR_TAPS;
      end
    endfunction

    // lowest valid slot with the same key and kind, -1 if none
    function int lowest_match(logic [63:0] key, logic kind);
      int idx;
      idx = -1;
      for (int i = tacrr_pkg::ENTRIES - 1; i >= 0; i--) begin
        if (slot_valid[i] && slot_key[i] == key && slot_kind[i] == kind) begin
          idx = i;
        end
      end
      return idx;
    endfunction

    function void note_request(logic [1:0] action, logic [63:0] key, logic kind,
                               logic [63:0] payload);
      int idx;
      cache_reply_t r;
      idx = -1;
      r.status = 1'b1;
      r.slot   = 4'd0;
      r.rdata  = 64'd0;
      case (action)
        tacrr_pkg::ACT_ADD: begin
          for (int i = tacrr_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (!slot_valid[i]) begin
              idx = i;
            end
          end
          // full cache: step the lfsr, then pick the victim
          if (idx < 0) begin
            step_lfsr();
            idx = int'(victim_lfsr % tacrr_pkg::ENTRIES);
          end
          slot_valid[idx] = 1'b1;
          slot_key[idx]   = key;
          slot_kind[idx]  = kind;
          slot_data[idx]  = payload;
          r.status = 1'b0;
          r.slot   = 4'(idx);
        end
        tacrr_pkg::ACT_LOOKUP: begin
          idx = lowest_match(key, kind);
          if (idx >= 0) begin
            r.status = 1'b0;
            r.slot   = 4'(idx);
            r.rdata  = slot_data[idx];
          end
        end
        tacrr_pkg::ACT_UPDATE: begin
          idx = lowest_match(key, kind);
          if (idx >= 0) begin
            slot_data[idx] = payload;
            r.status = 1'b0;
            r.slot   = 4'(idx);
          end
        end
        default: begin
        end
      endcase
      expected_replies.push_back(r);
    endfunction

    function void check_response(cache_reply_t got);
      cache_reply_t want;
      reply_count++;
      if (expected_replies.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("reply %0d not expected: status %0b slot %0d data %h",
                   reply_count, got.status, got.slot, got.rdata);
        end
        return;
      end
      want = expected_replies.pop_front();
      if (got.status !== want.status || got.slot !== want.slot ||
          got.rdata !== want.rdata) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("reply %0d: expected status %0b slot %0d data %h, got %0b %0d %h",
                   reply_count, want.status, want.slot, want.rdata,
                   got.status, got.slot, got.rdata);
        end
      end
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;   // action[1:0], key[65:2], payload[129:66], zero
  logic         s_axis_tuser = 1'b0; // kind
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;        // slot[3:0], read_data[67:4], zero
  logic         m_axis_tuser;        // status
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [15:0]  cfg_data_i = '0;

  cache_scoreboard sb;
  logic [63:0] key_pool [POOL_KEYS];
  bit tx_stall_en = 1'b1;
  bit rx_stall_en = 1'b1;
  int rx_hold = 0;
  int cycle_count = 0;

  tagged_assoc_cache_random_replace dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tagged_assoc_cache_random_replace: mismatch");
      $finish;
    end
  end

  // result side back-pressure in random bursts
  always @(posedge clk_i) begin
    if (!rx_stall_en) begin
      m_axis_tready <= 1'b1;
      rx_hold <= 0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if (m_axis_tready && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      rx_hold <= $urandom_range(0, 14);
    end else begin
      m_axis_tready <= 1'b1;
      rx_hold <= $urandom_range(0, 40);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    cache_reply_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tuser;
      got.slot   = m_axis_tdata[3:0];
      got.rdata  = m_axis_tdata[67:4];
      sb.check_response(got);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // present one item and hold it until accepted
  task automatic send_item(input logic [1:0] action, input logic [63:0] key,
                           input logic kind, input logic [63:0] payload);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, payload, key, action};
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    sb.note_request(action, key, kind, payload);
  endtask

  // mostly pool keys so lookups and updates hit, some fresh keys as noise
  task automatic send_random_item();
    int pick;
    logic [1:0] action;
    logic [63:0] key;
    if (tx_stall_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      action = tacrr_pkg::ACT_ADD;
    end else if (pick < 70) begin
      action = tacrr_pkg::ACT_LOOKUP;
    end else if (pick < 95) begin
      action = tacrr_pkg::ACT_UPDATE;
    end else begin
      action = ACT_UNUSED;
    end
    if ($urandom_range(0, 99) < 85) begin
      key = key_pool[$urandom_range(0, POOL_KEYS - 1)];
    end else begin
      key = rand64();
    end
    send_item(action, key, 1'($urandom_range(0, 1)), rand64());
  endtask

  // seed writes only once every reply is back
  task automatic write_seed(input logic [15:0] seed);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= seed;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    sb.load_seed(seed);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [15:0] phase_seed [5];
    logic [63:0] ones;
    sb = new();
    ones = '1;
    phase_seed[1] = 16'd1;
    phase_seed[2] = 16'hFFFF;
    phase_seed[3] = 16'd0;
    phase_seed[4] = 16'($urandom_range(2, 65534));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: misses on an empty cache, unused action
    send_item(tacrr_pkg::ACT_LOOKUP, 64'd0, 1'b0, 64'd0);
    send_item(tacrr_pkg::ACT_UPDATE, ones, 1'b1, ones);
    send_item(ACT_UNUSED, rand64(), 1'b1, rand64());
    // same key with both kinds, then a duplicate key
    send_item(tacrr_pkg::ACT_ADD, 64'd0, 1'b0, 64'd0);
    send_item(tacrr_pkg::ACT_ADD, ones, 1'b1, ones);
    send_item(tacrr_pkg::ACT_ADD, ones, 1'b0, rand64());
    send_item(tacrr_pkg::ACT_ADD, 64'd0, 1'b0, ones);
    send_item(tacrr_pkg::ACT_LOOKUP, 64'd0, 1'b0, 64'd0);
    send_item(tacrr_pkg::ACT_LOOKUP, ones, 1'b1, 64'd0);
    send_item(tacrr_pkg::ACT_LOOKUP, 64'd0, 1'b1, 64'd0);
    send_item(tacrr_pkg::ACT_UPDATE, 64'd0, 1'b0, rand64());
    send_item(tacrr_pkg::ACT_LOOKUP, 64'd0, 1'b0, ones);
    // fill the cache and run into victim replacement
    for (int i = 0; i < 14; i++) begin
      send_item(tacrr_pkg::ACT_ADD, rand64(), 1'($urandom_range(0, 1)), rand64());
    end

    // random phases, each with its own key pool, all but the first after a seed write
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        write_seed(phase_seed[ph]);
      end
      if (ph == 4) begin
        tx_stall_en = 1'b0;
        rx_stall_en = 1'b0;
      end
      for (int k = 0; k < POOL_KEYS; k++) begin
        key_pool[k] = rand64();
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_random_item();
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (30) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("tagged_assoc_cache_random_replace: match");
    end else begin
      $display("tagged_assoc_cache_random_replace: mismatch");
    end
    $finish;
  end

endmodule
